// ===== hdl/mlpq_pkg.sv =====
`timescale 1ns / 1ps
package mlpq_pkg;

	localparam int PRIO_W       = 16;
	localparam int HANDLE_W     = 16;
	localparam int LIU_W        = 4;
	localparam int LEVEL_OUT_W  = 3;
	localparam int MUL_W        = PRIO_W + LIU_W;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	localparam int NUM_LEVELS_DEF  = 8;
	localparam int LEVEL_DEPTH_DEF = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRIORITY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_IN_USE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STACK_MODE    = 2'd2;

	localparam logic [PRIO_W-1:0] MAX_PRIORITY_RST  = '0;
	localparam logic [LIU_W-1:0]  LEVELS_IN_USE_RST = 4'd8;

	typedef enum logic {
		CMD_ENQUEUE,
		CMD_DEQUEUE
	} command_t;

	typedef enum logic [1:0] {
		ST_ENQUEUED,
		ST_DEQUEUED,
		ST_EMPTY,
		ST_FULL
	} status_t;

	typedef struct packed {
		command_t            command;
		logic [HANDLE_W-1:0] task_handle;
		logic [PRIO_W-1:0]   task_priority;
	} item_t;

	typedef struct packed {
		status_t                status;
		logic [HANDLE_W-1:0]    out_handle;
		logic [LEVEL_OUT_W-1:0] level_used;
		logic                   was_saturated;
	} result_t;

	typedef struct packed {
		logic              start;
		logic [MUL_W-1:0]  dividend;
		logic [PRIO_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [MUL_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hdl/mlpq_div.sv =====
`timescale 1ns / 1ps
module mlpq_div (
	input  logic              clk,
	input  logic              arst_n,
	input  mlpq_pkg::div_req_t req,
	output mlpq_pkg::div_rsp_t rsp
);
	import mlpq_pkg::*;

	localparam int CNT_W = $clog2(MUL_W + 1);

	logic [PRIO_W-1:0] rem_q;
	logic [MUL_W-1:0]  quo_q;
	logic [PRIO_W-1:0] divisor_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [PRIO_W:0]   shifted;
	logic              take;
	logic [PRIO_W:0]   diff;

	assign shifted = {rem_q, quo_q[MUL_W-1]};
	assign take    = shifted >= {1'b0, divisor_q};
	assign diff    = shifted - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			quo_q     <= '0;
			divisor_q <= '0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= !req.start && (cnt_q == CNT_W'(1));
			if (req.start) begin
				rem_q     <= '0;
				quo_q     <= req.dividend;
				divisor_q <= req.divisor;
				cnt_q     <= CNT_W'(MUL_W);
			end else if (cnt_q != '0) begin
				rem_q <= take ? diff[PRIO_W-1:0] : shifted[PRIO_W-1:0];
				quo_q <= {quo_q[MUL_W-2:0], take};
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== hdl/multi_level_priority_queue.sv =====
`timescale 1ns / 1ps
// channel   signals                                   direction  handshake
// command   start, busy, item                         in         start && !busy
// result    result_strobe, result                     out        one-cycle strobe
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in         valid && ready
//
// enqueue: MUL, then DIV on the 20-step restoring divider for the level map, then PLACE
// dequeue: one level scanned per cycle from the top level in use, then a registered read
// a new word may start in the cycle its predecessor's result is strobed
// reset clears the head pointers and fill counts; the entry memory needs no clearing
// the receiver cannot stall; results are never held off
module multi_level_priority_queue #(
	parameter int NUM_LEVELS  = mlpq_pkg::NUM_LEVELS_DEF,
	parameter int LEVEL_DEPTH = mlpq_pkg::LEVEL_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  mlpq_pkg::item_t                    item,
	output logic                               result_strobe,
	output mlpq_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mlpq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mlpq_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mlpq_pkg::*;

	localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int HW = $clog2(LEVEL_DEPTH);
	localparam int CW = $clog2(LEVEL_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int AW = $clog2(NUM_LEVELS * LEVEL_DEPTH);
	localparam int MEM_DEPTH = NUM_LEVELS * LEVEL_DEPTH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_PLACE,
		S_SCAN,
		S_FETCH,
		S_POP
	} state_t;

	state_t              state_q;
	item_t               item_q;
	result_t             result_q;
	logic                strobe_q;
	logic [LW-1:0]       lvl_q;
	logic                sat_q;
	logic [PRIO_W-1:0]   max_priority_q;
	logic [LIU_W-1:0]    levels_in_use_q;
	logic                stack_mode_q;
	logic [HW-1:0]       heads_q [NUM_LEVELS];
	logic [CW-1:0]       counts_q [NUM_LEVELS];
	logic [HANDLE_W-1:0] mem [MEM_DEPTH];
	logic [HANDLE_W-1:0] rd_q;

	logic [LIU_W-1:0]    nlev;
	logic [LIU_W-1:0]    nlev_m1;
	div_req_t            div_req;
	div_rsp_t            div_rsp;
	logic                sat_c;
	logic [HW-1:0]       cur_head;
	logic [CW-1:0]       cur_cnt;
	logic                full_c;
	logic [HW-1:0]       head_dec;
	logic [HW-1:0]       head_inc;
	logic [SW-1:0]       slot_sum;
	logic [HW-1:0]       slot_fifo;
	logic [HW-1:0]       wr_slot;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [AW-1:0]       rd_addr;

	always_comb begin
		if (levels_in_use_q == '0) begin
			nlev = LIU_W'(1);
		end else if (32'(levels_in_use_q) > 32'(NUM_LEVELS)) begin
			nlev = LIU_W'(NUM_LEVELS);
		end else begin
			nlev = levels_in_use_q;
		end
	end

	assign nlev_m1 = nlev - 1'b1;

	assign div_req.start    = (state_q == S_MUL);
	assign div_req.dividend = MUL_W'(item_q.task_priority) * MUL_W'(nlev_m1);
	assign div_req.divisor  = (max_priority_q == '0) ? PRIO_W'(1) : max_priority_q;

	mlpq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign sat_c     = div_rsp.quotient >= MUL_W'(nlev);
	assign cur_head  = heads_q[lvl_q];
	assign cur_cnt   = counts_q[lvl_q];
	assign full_c    = cur_cnt >= CW'(LEVEL_DEPTH);
	assign head_dec  = (cur_head == '0) ? HW'(LEVEL_DEPTH - 1) : cur_head - 1'b1;
	assign head_inc  = (cur_head == HW'(LEVEL_DEPTH - 1)) ? '0 : cur_head + 1'b1;
	assign slot_sum  = SW'(cur_head) + SW'(cur_cnt);
	assign slot_fifo = (slot_sum >= SW'(LEVEL_DEPTH)) ? HW'(slot_sum - SW'(LEVEL_DEPTH))
		: HW'(slot_sum);
	assign wr_slot   = stack_mode_q ? head_dec : slot_fifo;
	assign wr_en     = (state_q == S_PLACE) && !full_c;
	assign wr_addr   = AW'(lvl_q) * AW'(LEVEL_DEPTH) + AW'(wr_slot);
	assign rd_addr   = AW'(lvl_q) * AW'(LEVEL_DEPTH) + AW'(cur_head);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= item_q.task_handle;
		end
		if (state_q == S_FETCH) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			item_q          <= '0;
			result_q        <= '0;
			strobe_q        <= 1'b0;
			lvl_q           <= '0;
			sat_q           <= 1'b0;
			max_priority_q  <= MAX_PRIORITY_RST;
			levels_in_use_q <= LEVELS_IN_USE_RST;
			stack_mode_q    <= 1'b0;
			for (int i = 0; i < NUM_LEVELS; i++) begin
				heads_q[i]  <= '0;
				counts_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_MAX_PRIORITY:  max_priority_q  <= cfg_data[PRIO_W-1:0];
					CFG_LEVELS_IN_USE: levels_in_use_q <= cfg_data[LIU_W-1:0];
					CFG_STACK_MODE:    stack_mode_q    <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					strobe_q <= 1'b0;
					if (start) begin
						item_q <= item;
						if (item.command == CMD_DEQUEUE) begin
							lvl_q   <= LW'(nlev_m1);
							state_q <= S_SCAN;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						lvl_q   <= sat_c ? LW'(nlev_m1) : LW'(div_rsp.quotient);
						sat_q   <= sat_c;
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					result_q.status        <= full_c ? ST_FULL : ST_ENQUEUED;
					result_q.out_handle    <= '0;
					result_q.level_used    <= LEVEL_OUT_W'(lvl_q);
					result_q.was_saturated <= sat_q;
					strobe_q               <= 1'b1;
					if (!full_c) begin
						counts_q[lvl_q] <= cur_cnt + 1'b1;
						if (stack_mode_q) begin
							heads_q[lvl_q] <= head_dec;
						end
					end
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (cur_cnt != '0) begin
						state_q <= S_FETCH;
					end else if (lvl_q == '0) begin
						result_q.status        <= ST_EMPTY;
						result_q.out_handle    <= '0;
						result_q.level_used    <= '0;
						result_q.was_saturated <= 1'b0;
						strobe_q               <= 1'b1;
						state_q                <= S_IDLE;
					end else begin
						lvl_q <= lvl_q - 1'b1;
					end
				end
				S_FETCH: begin
					state_q <= S_POP;
				end
				S_POP: begin
					result_q.status        <= ST_DEQUEUED;
					result_q.out_handle    <= rd_q;
					result_q.level_used    <= LEVEL_OUT_W'(lvl_q);
					result_q.was_saturated <= 1'b0;
					strobe_q               <= 1'b1;
					heads_q[lvl_q]         <= head_inc;
					counts_q[lvl_q]        <= cur_cnt - 1'b1;
					state_q                <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign cfg_ready     = 1'b1;
	assign result_strobe = strobe_q;
	assign result        = result_q;

	a_strobe_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> !busy)
		else $error("result strobed while a word is still in progress");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not occupy the sequencer");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(counts_q[lvl_q]) <= 32'(LEVEL_DEPTH))
		else $error("level fill count beyond level depth");

	a_level_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE) |-> (32'(lvl_q) < 32'(nlev)))
		else $error("enqueue level outside the levels in use");

endmodule

// ===== tb/mlpq_checker.sv =====
`timescale 1ns / 1ps
module mlpq_checker #(
	parameter int NUM_LEVELS  = mlpq_pkg::NUM_LEVELS_DEF,
	parameter int LEVEL_DEPTH = mlpq_pkg::LEVEL_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  mlpq_pkg::item_t                    item,
	input  logic                               result_strobe,
	input  mlpq_pkg::result_t                  result,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [mlpq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mlpq_pkg::CFG_DATA_W-1:0]    cfg_data,
	output int                                 errors,
	output int                                 pending
);
	import mlpq_pkg::*;

	logic [HANDLE_W-1:0] slot_handles [NUM_LEVELS][LEVEL_DEPTH];
	int unsigned         front_idx [NUM_LEVELS];
	int unsigned         fill [NUM_LEVELS];
	logic [PRIO_W-1:0]   max_prio;
	logic [LIU_W-1:0]    levels_used;
	logic                lifo;

	result_t outcomes_due[$];
	result_t want;
	int      err_count;

	function automatic result_t ready_queue_outcome(item_t w);
		result_t     r;
		int unsigned nlev;
		int unsigned divisor;
		int unsigned lvl;
		int unsigned slot;
		r = '0;
		nlev = levels_used;
		if (nlev == 0) nlev = 1;
		if (nlev > NUM_LEVELS) nlev = NUM_LEVELS;
		if (w.command == CMD_ENQUEUE) begin
			divisor = (max_prio == 0) ? 1 : max_prio;
			lvl = (w.task_priority * (nlev - 1)) / divisor;
			if (lvl >= nlev) begin
				lvl = nlev - 1;
				r.was_saturated = 1'b1;
			end
			r.level_used = LEVEL_OUT_W'(lvl);
			if (fill[lvl] >= LEVEL_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				if (lifo) begin
					front_idx[lvl] = (front_idx[lvl] == 0) ? LEVEL_DEPTH - 1 : front_idx[lvl] - 1;
					slot = front_idx[lvl];
				end else begin
					slot = front_idx[lvl] + fill[lvl];
					if (slot >= LEVEL_DEPTH) slot -= LEVEL_DEPTH;
				end
				slot_handles[lvl][slot] = w.task_handle;
				fill[lvl]++;
				r.status = ST_ENQUEUED;
			end
		end else begin
			r.status = ST_EMPTY;
			for (int i = int'(nlev) - 1; i >= 0; i--) begin
				if (fill[i] != 0) begin
					r.status = ST_DEQUEUED;
					r.out_handle = slot_handles[i][front_idx[i]];
					r.level_used = LEVEL_OUT_W'(i);
					front_idx[i] = (front_idx[i] + 1 >= LEVEL_DEPTH) ? 0 : front_idx[i] + 1;
					fill[i]--;
					break;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				front_idx[i] = 0;
				fill[i] = 0;
			end
			max_prio = MAX_PRIORITY_RST;
			levels_used = LEVELS_IN_USE_RST;
			lifo = 1'b0;
			outcomes_due.delete();
			err_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (result_strobe) begin
				if (outcomes_due.size() == 0) begin
					$error("result word with none pending: %p", result);
					err_count++;
				end else begin
					want = outcomes_due[0];
					outcomes_due.delete(0);
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						err_count++;
					end
					if (result.out_handle !== want.out_handle) begin
						$error("out_handle: expected %h, got %h", want.out_handle,
							result.out_handle);
						err_count++;
					end
					if (result.level_used !== want.level_used) begin
						$error("level_used: expected %0d, got %0d", want.level_used,
							result.level_used);
						err_count++;
					end
					if (result.was_saturated !== want.was_saturated) begin
						$error("was_saturated: expected %0b, got %0b", want.was_saturated,
							result.was_saturated);
						err_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MAX_PRIORITY: max_prio = cfg_data[PRIO_W-1:0];
					CFG_LEVELS_IN_USE: levels_used = cfg_data[LIU_W-1:0];
					CFG_STACK_MODE: lifo = cfg_data[0];
					default: ;
				endcase
			end
			if (start && !busy) outcomes_due.insert(outcomes_due.size(), ready_queue_outcome(item));
			errors <= err_count;
			pending <= outcomes_due.size();
		end
	end

endmodule

// ===== tb/tb_multi_level_priority_queue.sv =====
`timescale 1ns / 1ps
module tb_multi_level_priority_queue;
	import mlpq_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
	localparam int PHASES          = 12;
	localparam int WORDS_PER_PHASE = 118;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	item_t                  item;
	logic                   result_strobe;
	result_t                result;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     errors;
	int                     pending;
	logic                   idling;

	multi_level_priority_queue i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result_strobe (result_strobe),
		.result        (result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	mlpq_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result_strobe (result_strobe),
		.result        (result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic send_word(input command_t op, input logic [HANDLE_W-1:0] handle,
		input logic [PRIO_W-1:0] prio);
		item_t w;
		w.command = op;
		w.task_handle = handle;
		w.task_priority = prio;
		if (idling && $urandom_range(0, 99) < 6) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
	endtask

	task automatic await_quiet();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// leaves valid high so back-to-back writes need no extra edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [PRIO_W-1:0] mp, input logic [LIU_W-1:0] liu,
		input logic stk, input logic junk);
		write_reg(CFG_MAX_PRIORITY, mp);
		write_reg(CFG_LEVELS_IN_USE, (16'($urandom) & 16'hFFF0) | 16'(liu));
		write_reg(CFG_STACK_MODE, (16'($urandom) & 16'hFFFE) | 16'(stk));
		if (junk) write_reg(CFG_UNUSED_INDEX, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [PRIO_W-1:0] pick_priority(input logic [PRIO_W-1:0] mp);
		int unsigned span;
		span = mp + mp / 4 + 1;
		if (span > 65535) span = 65535;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom);
			default: return 16'($urandom_range(0, span));
		endcase
	endfunction

	initial begin
		logic [PRIO_W-1:0] mp;
		logic [LIU_W-1:0]  liu;
		int                enq_pct;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idling = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, extremes of priority, saturation with a zero maximum
		send_word(CMD_DEQUEUE, 16'hFFFF, 16'hFFFF);
		send_word(CMD_ENQUEUE, 16'hFFFF, 16'h0000);
		send_word(CMD_ENQUEUE, 16'h0000, 16'hFFFF);
		send_word(CMD_ENQUEUE, 16'h1234, 16'h0001);
		send_word(CMD_ENQUEUE, 16'hAAAA, 16'h0002);
		repeat (4) send_word(CMD_DEQUEUE, 16'h5555, 16'h0000);
		send_word(CMD_DEQUEUE, 16'h0000, 16'h0000);
		await_quiet();

		// zero levels in use counts as one; overfill that level
		configure(16'd0, 4'd0, 1'b0, 1'b1);
		repeat (17) send_word(CMD_ENQUEUE, 16'($urandom), 16'($urandom));

		for (int p = 0; p < PHASES; p++) begin
			await_quiet();
			case (p % 6)
				0: mp = 16'd0;
				1: mp = 16'hFFFF;
				2: mp = 16'd1;
				3: mp = 16'($urandom_range(2, 40));
				4: mp = 16'($urandom);
				default: mp = 16'($urandom_range(100, 2000));
			endcase
			case (p)
				0: liu = 4'd8;
				1: liu = 4'd1;
				2: liu = 4'd15;
				3: liu = 4'd0;
				default: liu = 4'($urandom_range(0, 15));
			endcase
			enq_pct = (p % 3 == 0) ? 70 : (p % 3 == 1) ? 50 : 35;
			idling = !(p == 3 || p == 4);
			configure(mp, liu, 1'((p >> 1) & 1), p % 4 == 0);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) < enq_pct)
					send_word(CMD_ENQUEUE, 16'($urandom), pick_priority(mp));
				else
					send_word(CMD_DEQUEUE, 16'($urandom), 16'($urandom));
				if ($urandom_range(0, 199) == 0) await_quiet();
			end
		end

		await_quiet();
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
